FILE: design/pcc_pkg.sv
package pcc_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_PROP_GAIN    = 3'd0;
  localparam cfg_idx_t CFG_INTEG_GAIN   = 3'd1;
  localparam cfg_idx_t CFG_DERIV_GAIN   = 3'd2;
  localparam cfg_idx_t CFG_INTEG_OFFSET = 3'd3;
  localparam cfg_idx_t CFG_INTEG_LIMIT  = 3'd4;
  localparam cfg_idx_t CFG_OUT_MAX      = 3'd5;
  localparam cfg_idx_t CFG_OUT_MIN      = 3'd6;

  // Integral limit after reset: 1.0 in Q16.16.
  localparam int INTEG_LIMIT_RST = 65536;

endpackage

FILE: design/pid_controller_clamped_unit.sv
// After its input transaction is accepted, the drive value passes the input register,
// then the result register. The accumulator update is one registered pass.
// Throughput: one sample per cycle while the output is not stalled.
// Reset: gains and offset clear, integral limit is 1.0, output bounds open fully,
// accumulator and previous error clear, and the next sample is treated as first.
module pid_controller_clamped_unit #(
  parameter int DATA_WIDTH = pcc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pcc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  pcc_pkg::cfg_idx_t             cfg_idx_i,
  input  logic [DATA_WIDTH-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [DATA_WIDTH-1:0]  error_in_i,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [DATA_WIDTH-1:0]  drive_o
);

  logic signed [DATA_WIDTH-1:0] prop_gain, integ_gain, deriv_gain, integ_offset;
  logic [DATA_WIDTH-2:0]        integ_limit;
  logic signed [DATA_WIDTH-1:0] out_max, out_min;

  logic                         in_vld_q, in_vld_d;
  logic signed [DATA_WIDTH-1:0] err_q;
  logic                         restart_q;
  logic                         out_vld_q, out_vld_d;
  logic signed [DATA_WIDTH-1:0] drive_q;
  logic signed [DATA_WIDTH-1:0] drive_next;
  logic                         in_take, advance, out_blocked;

  pcc_cfg_regs #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .prop_gain_o    (prop_gain),
    .integ_gain_o   (integ_gain),
    .deriv_gain_o   (deriv_gain),
    .integ_offset_o (integ_offset),
    .integ_limit_o  (integ_limit),
    .out_max_o      (out_max),
    .out_min_o      (out_min)
  );

  // The held sample moves on whenever the result register is free or being emptied.
  assign out_blocked = out_vld_q & out_stall_i;
  assign advance     = in_vld_q & ~out_blocked;
  assign in_stall_o  = in_vld_q & out_blocked;
  assign in_take     = in_valid_i & ~in_stall_o;

  pcc_core #(
    .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .err_i          (err_q),
    .restart_i      (restart_q),
    .prop_gain_i    (prop_gain),
    .integ_gain_i   (integ_gain),
    .deriv_gain_i   (deriv_gain),
    .integ_offset_i (integ_offset),
    .integ_limit_i  (integ_limit),
    .out_max_i      (out_max),
    .out_min_i      (out_min),
    .drive_o        (drive_next)
  );

  always_comb begin
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end

    if (advance) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q & ~out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      err_q     <= error_in_i;
      restart_q <= restart_i;
    end
    if (advance) begin
      drive_q <= drive_next;
    end
  end

  assign out_valid_o = out_vld_q;
  assign drive_o     = drive_q;

endmodule

FILE: design/pcc_cfg_regs.sv
module pcc_cfg_regs #(
  parameter int DATA_WIDTH = pcc_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  pcc_pkg::cfg_idx_t             cfg_idx_i,
  input  logic [DATA_WIDTH-1:0]         cfg_data_i,
  output logic signed [DATA_WIDTH-1:0]  prop_gain_o,
  output logic signed [DATA_WIDTH-1:0]  integ_gain_o,
  output logic signed [DATA_WIDTH-1:0]  deriv_gain_o,
  output logic signed [DATA_WIDTH-1:0]  integ_offset_o,
  output logic [DATA_WIDTH-2:0]         integ_limit_o,
  output logic signed [DATA_WIDTH-1:0]  out_max_o,
  output logic signed [DATA_WIDTH-1:0]  out_min_o
);

  localparam logic [DATA_WIDTH-2:0] LimitRst = (DATA_WIDTH-1)'(pcc_pkg::INTEG_LIMIT_RST);
  localparam logic [DATA_WIDTH-1:0] MaxRst   = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MinRst   = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic [DATA_WIDTH-1:0] prop_gain_q, integ_gain_q, deriv_gain_q, integ_offset_q;
  logic [DATA_WIDTH-2:0] integ_limit_q;
  logic [DATA_WIDTH-1:0] out_max_q, out_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q    <= '0;
      integ_gain_q   <= '0;
      deriv_gain_q   <= '0;
      integ_offset_q <= '0;
      integ_limit_q  <= LimitRst;
      out_max_q      <= MaxRst;
      out_min_q      <= MinRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pcc_pkg::CFG_PROP_GAIN:    prop_gain_q    <= cfg_data_i;
        pcc_pkg::CFG_INTEG_GAIN:   integ_gain_q   <= cfg_data_i;
        pcc_pkg::CFG_DERIV_GAIN:   deriv_gain_q   <= cfg_data_i;
        pcc_pkg::CFG_INTEG_OFFSET: integ_offset_q <= cfg_data_i;
        pcc_pkg::CFG_INTEG_LIMIT:  integ_limit_q  <= cfg_data_i[DATA_WIDTH-2:0];
        pcc_pkg::CFG_OUT_MAX:      out_max_q      <= cfg_data_i;
        pcc_pkg::CFG_OUT_MIN:      out_min_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign prop_gain_o    = $signed(prop_gain_q);
  assign integ_gain_o   = $signed(integ_gain_q);
  assign deriv_gain_o   = $signed(deriv_gain_q);
  assign integ_offset_o = $signed(integ_offset_q);
  assign integ_limit_o  = integ_limit_q;
  assign out_max_o      = $signed(out_max_q);
  assign out_min_o      = $signed(out_min_q);

endmodule

FILE: design/pcc_fx_mul.sv
// Fixed-point product: exact multiply, floor shift by FRAC_BITS, saturate.
module pcc_fx_mul #(
  parameter int A_WIDTH    = pcc_pkg::DATA_WIDTH_DEF,
  parameter int DATA_WIDTH = pcc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pcc_pkg::FRAC_BITS_DEF
) (
  input  logic signed [A_WIDTH-1:0]    a_i,
  input  logic signed [DATA_WIDTH-1:0] b_i,
  output logic signed [DATA_WIDTH-1:0] y_o
);

  localparam int PW = A_WIDTH + DATA_WIDTH;
  localparam logic signed [PW-1:0] SatHi =
    $signed({{(PW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
  localparam logic signed [PW-1:0] SatLo = ~SatHi;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] shifted;

  always_comb begin
    prod    = a_i * b_i;
    // Arithmetic shift rounds toward minus infinity.
    shifted = prod >>> FRAC_BITS;
    if (shifted > SatHi) begin
      y_o = SatHi[DATA_WIDTH-1:0];
    end else if (shifted < SatLo) begin
      y_o = SatLo[DATA_WIDTH-1:0];
    end else begin
      y_o = shifted[DATA_WIDTH-1:0];
    end
  end

endmodule

FILE: design/pcc_core.sv
// Controller state and the single-pass update for one sample.
module pcc_core #(
  parameter int DATA_WIDTH = pcc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pcc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic signed [DATA_WIDTH-1:0]  err_i,
  input  logic                          restart_i,
  input  logic signed [DATA_WIDTH-1:0]  prop_gain_i,
  input  logic signed [DATA_WIDTH-1:0]  integ_gain_i,
  input  logic signed [DATA_WIDTH-1:0]  deriv_gain_i,
  input  logic signed [DATA_WIDTH-1:0]  integ_offset_i,
  input  logic [DATA_WIDTH-2:0]         integ_limit_i,
  input  logic signed [DATA_WIDTH-1:0]  out_max_i,
  input  logic signed [DATA_WIDTH-1:0]  out_min_i,
  output logic signed [DATA_WIDTH-1:0]  drive_o
);

  logic signed [DATA_WIDTH-1:0] acc_q, acc_d;
  logic signed [DATA_WIDTH-1:0] last_err_q;
  logic                         first_q;

  logic signed [DATA_WIDTH:0]   err_diff;
  logic signed [DATA_WIDTH-1:0] iterm, dterm, pterm;
  logic signed [DATA_WIDTH+1:0] acc_sum, lim_pos, lim_neg;
  logic signed [DATA_WIDTH-1:0] acc_clamped;
  logic signed [DATA_WIDTH:0]   res_sum, res_hi, res_lo;
  logic signed [DATA_WIDTH-1:0] res_clamped;
  logic                         is_first;

  assign err_diff = (DATA_WIDTH+1)'(err_i) - (DATA_WIDTH+1)'(last_err_q);

  pcc_fx_mul #(
    .A_WIDTH(DATA_WIDTH), .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)
  ) u_mul_i (
    .a_i(err_i), .b_i(integ_gain_i), .y_o(iterm)
  );

  pcc_fx_mul #(
    .A_WIDTH(DATA_WIDTH+1), .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)
  ) u_mul_d (
    .a_i(err_diff), .b_i(deriv_gain_i), .y_o(dterm)
  );

  pcc_fx_mul #(
    .A_WIDTH(DATA_WIDTH), .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)
  ) u_mul_p (
    .a_i(err_i), .b_i(prop_gain_i), .y_o(pterm)
  );

  always_comb begin
    is_first = first_q | restart_i;

    acc_sum = (DATA_WIDTH+2)'(acc_q) + (DATA_WIDTH+2)'(iterm) + (DATA_WIDTH+2)'(dterm);
    lim_pos = $signed({3'b000, integ_limit_i});
    lim_neg = -lim_pos;
    if (acc_sum > lim_pos) begin
      acc_clamped = lim_pos[DATA_WIDTH-1:0];
    end else if (acc_sum < lim_neg) begin
      acc_clamped = lim_neg[DATA_WIDTH-1:0];
    end else begin
      acc_clamped = acc_sum[DATA_WIDTH-1:0];
    end

    // Upper bound tested first; if crossed, it wins for sums above it.
    res_sum = (DATA_WIDTH+1)'(acc_clamped) + (DATA_WIDTH+1)'(pterm);
    res_hi  = (DATA_WIDTH+1)'(out_max_i);
    res_lo  = (DATA_WIDTH+1)'(out_min_i);
    if (res_sum > res_hi) begin
      res_clamped = out_max_i;
    end else if (res_sum < res_lo) begin
      res_clamped = out_min_i;
    end else begin
      res_clamped = res_sum[DATA_WIDTH-1:0];
    end

    // First or restart samples load the offset and output it unclamped.
    if (is_first) begin
      acc_d   = integ_offset_i;
      drive_o = integ_offset_i;
    end else begin
      acc_d   = acc_clamped;
      drive_o = res_clamped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      last_err_q <= '0;
      first_q    <= 1'b1;
    end else if (step_i) begin
      acc_q      <= acc_d;
      last_err_q <= err_i;
      first_q    <= 1'b0;
    end
  end

endmodule

FILE: test/pid_controller_clamped_unit_checker.sv
`timescale 1ns / 1ps

module pid_controller_clamped_unit_checker (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  pcc_pkg::cfg_idx_t                         cfg_idx_i,
  input  logic [pcc_pkg::DATA_WIDTH_DEF-1:0]        cfg_data_i,
  input  logic                                      in_valid_i,
  input  logic                                      in_stall_i,
  input  logic signed [pcc_pkg::DATA_WIDTH_DEF-1:0] error_in_i,
  input  logic                                      restart_i,
  input  logic                                      out_valid_i,
  input  logic                                      out_stall_i,
  input  logic signed [pcc_pkg::DATA_WIDTH_DEF-1:0] drive_i,
  output int                                        fail_count_o,
  output int                                        pending_o
);

  localparam int DW = pcc_pkg::DATA_WIDTH_DEF;
  localparam int FB = pcc_pkg::FRAC_BITS_DEF;
  // Wide enough for an exact error difference times a gain.
  localparam int PW = 2 * DW + 16;

  typedef logic signed [DW-1:0] sample_t;
  typedef logic signed [PW-1:0] wide_t;

  localparam wide_t   SAT_HI     = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam wide_t   SAT_LO     = ~SAT_HI;
  localparam sample_t SAMPLE_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-2:0] LIMIT_RST = (DW-1)'(pcc_pkg::INTEG_LIMIT_RST);

  sample_t         prop_gain, integ_gain, deriv_gain, integ_offset, out_hi, out_lo;
  logic [DW-2:0]   acc_limit;
  sample_t         integ_acc, prev_error;
  logic            first_sample;
  sample_t         expected_drive_q[$];
  sample_t         wanted_drive;
  int              fail_count;

  // Q16.16 product, floored back to Q16.16 and saturated to the data width.
  function automatic sample_t fixed_product(input wide_t a, input wide_t b);
    wide_t p;
    p = (a * b) >>> FB;
    if (p > SAT_HI) p = SAT_HI;
    else if (p < SAT_LO) p = SAT_LO;
    return p[DW-1:0];
  endfunction

  function automatic sample_t next_drive(input sample_t err, input logic restart);
    longint lim, sum, level;
    if (restart) first_sample = 1'b1;
    if (first_sample) begin
      // The offset goes straight out, clamped by nothing.
      integ_acc    = integ_offset;
      prev_error   = err;
      first_sample = 1'b0;
      return integ_offset;
    end
    lim = longint'({1'b0, acc_limit});
    sum = longint'(integ_acc) + longint'(fixed_product(err, integ_gain))
        + longint'(fixed_product(longint'(err) - longint'(prev_error), deriv_gain));
    if (sum > lim) sum = lim;
    else if (sum < -lim) sum = -lim;
    integ_acc  = sample_t'(sum);
    prev_error = err;
    level = sum + longint'(fixed_product(err, prop_gain));
    if (level > longint'(out_hi)) level = longint'(out_hi);
    else if (level < longint'(out_lo)) level = longint'(out_lo);
    return sample_t'(level);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain    = '0;
      integ_gain   = '0;
      deriv_gain   = '0;
      integ_offset = '0;
      acc_limit    = LIMIT_RST;
      out_hi       = SAMPLE_MAX;
      out_lo       = SAMPLE_MIN;
      integ_acc    = '0;
      prev_error   = '0;
      first_sample = 1'b1;
      fail_count   = 0;
      expected_drive_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_drive_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: drive %0d (0x%08h) arrived with no sample pending",
                     $realtime, drive_i, drive_i);
          fail_count++;
        end else begin
          wanted_drive = expected_drive_q.pop_front();
          if (drive_i !== wanted_drive) begin
            if (fail_count < 10)
              $display("%0t: drive mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                       $realtime, wanted_drive, wanted_drive, drive_i, drive_i);
            fail_count++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pcc_pkg::CFG_PROP_GAIN:    prop_gain    = cfg_data_i;
          pcc_pkg::CFG_INTEG_GAIN:   integ_gain   = cfg_data_i;
          pcc_pkg::CFG_DERIV_GAIN:   deriv_gain   = cfg_data_i;
          pcc_pkg::CFG_INTEG_OFFSET: integ_offset = cfg_data_i;
          pcc_pkg::CFG_INTEG_LIMIT:  acc_limit    = cfg_data_i[DW-2:0];
          pcc_pkg::CFG_OUT_MAX:      out_hi       = cfg_data_i;
          pcc_pkg::CFG_OUT_MIN:      out_lo       = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_drive_q.push_back(next_drive(error_in_i, restart_i));
      fail_count_o <= fail_count;
      pending_o    <= expected_drive_q.size();
    end
  end

endmodule

FILE: test/pid_controller_clamped_unit_tb.sv
`timescale 1ns / 1ps

module pid_controller_clamped_unit_tb;

  localparam int LIMIT_CYCLES  = 100000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 60;
  // Index past the register list; the block must ignore writes to it.
  localparam pcc_pkg::cfg_idx_t CFG_UNMAPPED = 3'd7;

  typedef logic signed [pcc_pkg::DATA_WIDTH_DEF-1:0] sample_t;

  localparam sample_t Q_ONE      = 32'sd65536;
  localparam sample_t SAMPLE_MAX = 32'sh7FFFFFFF;
  localparam sample_t SAMPLE_MIN = 32'sh80000000;

  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               cfg_we_i    = 1'b0;
  pcc_pkg::cfg_idx_t                  cfg_idx_i   = pcc_pkg::CFG_PROP_GAIN;
  logic [pcc_pkg::DATA_WIDTH_DEF-1:0] cfg_data_i  = '0;
  logic                               in_valid_i  = 1'b0;
  sample_t                            error_in_i  = '0;
  logic                               restart_i   = 1'b0;
  logic                               out_stall_i = 1'b0;
  logic                               in_stall_o;
  logic                               out_valid_o;
  sample_t                            drive_o;

  logic    tx_idle_on = 1'b1;
  logic    rx_idle_on = 1'b1;
  logic    hold_off   = 1'b0;
  sample_t last_sent  = '0;
  int      fail_count;
  int      pending;
  int      cycle_count = 0;

  pid_controller_clamped_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .error_in_i  (error_in_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o)
  );

  pid_controller_clamped_unit_checker drive_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .error_in_i   (error_in_i),
    .restart_i    (restart_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .drive_i      (drive_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= rx_idle_on && ($urandom_range(99, 0) < 19);
  end

  task automatic send_sample(input sample_t err, input logic restart);
    while (tx_idle_on && $urandom_range(99, 0) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    error_in_i <= err;
    restart_i  <= restart;
    last_sent  = err;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Waits until every drive value has come back and the pipeline is quiet.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_settings(input sample_t kp, input sample_t ki, input sample_t kd,
                               input sample_t offset, input logic [31:0] limit,
                               input sample_t hi, input sample_t lo);
    pcc_pkg::cfg_idx_t idx [8];
    logic [31:0]       val [8];
    idx = '{pcc_pkg::CFG_PROP_GAIN, pcc_pkg::CFG_INTEG_GAIN, pcc_pkg::CFG_DERIV_GAIN,
            pcc_pkg::CFG_INTEG_OFFSET, pcc_pkg::CFG_INTEG_LIMIT, pcc_pkg::CFG_OUT_MAX,
            pcc_pkg::CFG_OUT_MIN, CFG_UNMAPPED};
    val = '{kp, ki, kd, offset, limit, hi, lo, $urandom()};
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Mostly values within +-8.0, now and then the full range.
  function automatic sample_t rand_level();
    if ($urandom_range(3, 0) == 0) return $urandom();
    return $urandom_range(16 * 65536, 0) - 8 * 65536;
  endfunction

  task automatic load_random_settings();
    sample_t     a, b, t;
    logic [31:0] limit;
    a = rand_level();
    b = rand_level();
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    if ($urandom_range(3, 0) == 0) limit = $urandom();
    else limit = $urandom_range(4 * 65536, 0);
    // Once in a while the output bounds cross each other.
    if ($urandom_range(5, 0) == 0)
      load_settings(rand_level(), rand_level(), rand_level(), rand_level(), limit, a, b);
    else
      load_settings(rand_level(), rand_level(), rand_level(), rand_level(), limit, b, a);
  endtask

  // Error samples mostly follow a slow drift, as a real loop would see.
  function automatic sample_t pick_error(input sample_t prev);
    sample_t corners [5];
    corners = '{SAMPLE_MAX, SAMPLE_MIN, 32'sd0, -32'sd1, 32'sd1};
    case ($urandom_range(9, 0))
      0: return $urandom();
      1: return corners[$urandom_range(4, 0)];
      default: return prev + $urandom_range(65536, 0) - 32768;
    endcase
  endfunction

  task automatic run_random(input int count);
    sample_t e;
    e = last_sent;
    for (int n = 0; n < count; n++) begin
      e = pick_error(e);
      send_sample(e, $urandom_range(19, 0) == 0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero gains, so only the first transaction's offset matters.
    send_sample(Q_ONE, 1'b0);
    send_sample(-Q_ONE, 1'b0);
    drain();

    // Offset of 3.0 lies outside both the integral limit and the output bounds.
    load_settings(32'sd98304, 32'sd16384, 32'sd32768, 32'sd196608, 32'd131072,
                  32'sd98304, -32'sd98304);
    send_sample(Q_ONE, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd1, 1'b0);
    send_sample(Q_ONE, 1'b1);
    send_sample(-2 * Q_ONE, 1'b0);
    send_sample(Q_ONE / 2, 1'b0);
    drain();

    // Extreme gains; the limit write also has its unused top bit set.
    load_settings(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 32'hFFFFFFFF,
                  SAMPLE_MAX, SAMPLE_MIN);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd0, 1'b1);
    send_sample(32'sd1, 1'b0);
    drain();

    // Zero integral limit and crossed output bounds.
    load_settings(Q_ONE, -Q_ONE, SAMPLE_MIN, SAMPLE_MAX, 32'd0, -Q_ONE, Q_ONE);
    send_sample(32'sd0, 1'b1);
    send_sample(Q_ONE, 1'b0);
    send_sample(-4 * Q_ONE, 1'b0);
    send_sample(4 * Q_ONE, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      load_random_settings();
      tx_idle_on = (ph != 3);
      rx_idle_on <= (ph != 3);
      if (ph == 1) begin
        // The receiver holds off long enough for the block to back up.
        fork
          begin
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk_i);
            hold_off <= 1'b0;
          end
          run_random(67);
        join
      end else begin
        run_random(67);
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
